/* hdl/m3i_pkg.sv */
package m3i_pkg;

    // default element format, signed Q16.16
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int NUM_ELEM  = 9;
    localparam int NUM_TERMS = 6;
    // register stages from an accepted beat to a registered determinant magnitude
    localparam int DET_LAT   = 6;

    // rule of Sarrus: first three terms add, last three subtract
    localparam int DET_IDX [NUM_TERMS][3] = '{
        '{0, 4, 8}, '{1, 5, 6}, '{2, 3, 7},
        '{6, 4, 2}, '{3, 1, 8}, '{0, 7, 5}
    };

    // adjugate element i = a[x]*a[y] - a[u]*a[v], row-major output order
    localparam int COF_IDX [NUM_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic neg;
        logic zero;
    } det_flags_t;

    typedef struct packed {
        logic ovf;
        logic sing;
    } lane_stat_t;

endpackage

/* hdl/m3i_det.sv */
module m3i_det #(
    parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic [8:0][DATA_WIDTH-1:0]             mat,
    output logic [3*DATA_WIDTH-1:0]                det_mag,
    output m3i_pkg::det_flags_t                    det_flags
);
    import m3i_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2 * DW;
    localparam int TW   = 3 * DW;
    localparam int DETW = TW + 1;

    logic signed [PW-1:0]   p_reg   [NUM_TERMS];
    logic signed [DW-1:0]   c_reg   [NUM_TERMS];
    logic signed [PW-1:0]   hc_reg  [NUM_TERMS];
    logic signed [PW:0]     lc_reg  [NUM_TERMS];
    logic signed [TW-1:0]   trm_reg [NUM_TERMS];
    logic signed [DETW-1:0] pos_reg, neg_reg, det_reg;
    logic [TW-1:0]          mag_reg;
    det_flags_t             flags_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                // pair product, third factor carried
                p_reg[t]   <= $signed(mat[DET_IDX[t][0]]) * $signed(mat[DET_IDX[t][1]]);
                c_reg[t]   <= $signed(mat[DET_IDX[t][2]]);
                // split the pair product into two narrow multiplies
                hc_reg[t]  <= $signed(p_reg[t][PW-1:DW]) * c_reg[t];
                lc_reg[t]  <= $signed({1'b0, p_reg[t][DW-1:0]}) * c_reg[t];
                // recombine halves
                trm_reg[t] <= $signed({hc_reg[t], {DW{1'b0}}}) + TW'(lc_reg[t]);
            end
            // positive and negative diagonals
            pos_reg <= DETW'(trm_reg[0]) + DETW'(trm_reg[1]) + DETW'(trm_reg[2]);
            neg_reg <= DETW'(trm_reg[3]) + DETW'(trm_reg[4]) + DETW'(trm_reg[5]);
            det_reg <= pos_reg - neg_reg;
            // magnitude and flags
            mag_reg        <= det_reg[DETW-1] ? TW'(-det_reg) : TW'(det_reg);
            flags_reg.neg  <= det_reg[DETW-1];
            flags_reg.zero <= (det_reg == '0);
        end
    end

    assign det_mag   = mag_reg;
    assign det_flags = flags_reg;

endmodule

/* hdl/m3i_lane.sv */
module m3i_lane #(
    parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [DATA_WIDTH-1:0]  x,
    input  logic signed [DATA_WIDTH-1:0]  y,
    input  logic signed [DATA_WIDTH-1:0]  u,
    input  logic signed [DATA_WIDTH-1:0]  v,
    input  logic [DATA_WIDTH-1:0]         own,
    input  logic [3*DATA_WIDTH-1:0]       det_mag,
    input  m3i_pkg::det_flags_t           det_flags,
    output logic [DATA_WIDTH-1:0]         b,
    output m3i_pkg::lane_stat_t           stat
);
    import m3i_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int PW    = 2 * DW;
    localparam int CW    = PW + 1;
    localparam int MW    = PW;
    localparam int DMW   = 3 * DW;
    localparam int TWO_F = 2 * FRAC_BITS;
    localparam int NW    = MW + TWO_F;
    localparam int NTW   = NW - DW;
    localparam int RW    = ((NTW > DMW) ? NTW : DMW) + 1;
    localparam int DLY   = DET_LAT - 3;
    localparam int OWN_D = DET_LAT + DW + 1;
    localparam logic [DW:0] HALF = (DW + 1)'(1) << (DW - 1);

    // cofactor front end
    logic signed [PW-1:0] pxy_reg, puv_reg;
    logic signed [CW-1:0] cof_reg;
    logic [MW-1:0]        cmag_reg [DLY + 1];
    logic                 cneg_reg [DLY + 1];
    logic [DW-1:0]        own_reg  [OWN_D];

    // divider stages, index 0 is the setup stage
    logic [RW-1:0]  rem_reg  [DW + 1];
    logic [DW-1:0]  q_reg    [DW + 1];
    logic [DW-1:0]  low_reg  [DW + 1];
    logic [DMW-1:0] dmag_reg [DW + 1];
    logic           neg_reg  [DW + 1];
    logic           big_reg  [DW + 1];
    logic           zero_reg [DW + 1];
    logic [RW-1:0]  rem_next [DW + 1];
    logic [DW-1:0]  q_next   [DW + 1];
    logic [RW-1:0]  trial    [DW];
    logic           ge_bit   [DW];

    logic [NW-1:0]  num;
    logic [DW-1:0]  b_reg;
    lane_stat_t     stat_reg;
    logic           rnd;
    logic [DW:0]    qr, lim, qmag, qval;
    logic           sat;

    // numerator setup and one restoring step per stage
    always_comb begin
        num         = NW'(cmag_reg[DLY]) << TWO_F;
        rem_next[0] = RW'(num[NW-1:DW]);
        q_next[0]   = '0;
        for (int k = 0; k < DW; k++) begin
            trial[k]      = {rem_reg[k][RW-2:0], low_reg[k][DW-1-k]};
            ge_bit[k]     = (trial[k] >= RW'(dmag_reg[k]));
            rem_next[k+1] = ge_bit[k] ? trial[k] - RW'(dmag_reg[k]) : trial[k];
            q_next[k+1]   = {q_reg[k][DW-2:0], ge_bit[k]};
        end
    end

    // round to nearest, ties away, then saturate and apply sign
    always_comb begin
        rnd  = ({rem_reg[DW], 1'b0} >= (RW + 1)'(dmag_reg[DW]));
        qr   = (DW + 1)'(q_reg[DW]) + (DW + 1)'(rnd);
        lim  = neg_reg[DW] ? HALF : HALF - (DW + 1)'(1);
        sat  = big_reg[DW] || (qr > lim);
        qmag = sat ? lim : qr;
        qval = neg_reg[DW] ? -qmag : qmag;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pxy_reg     <= x * y;
            puv_reg     <= u * v;
            cof_reg     <= CW'(pxy_reg) - CW'(puv_reg);
            cmag_reg[0] <= cof_reg[CW-1] ? MW'(-cof_reg) : MW'(cof_reg);
            cneg_reg[0] <= cof_reg[CW-1];
            for (int i = 1; i <= DLY; i++) begin
                cmag_reg[i] <= cmag_reg[i-1];
                cneg_reg[i] <= cneg_reg[i-1];
            end
            own_reg[0] <= own;
            for (int i = 1; i < OWN_D; i++) begin
                own_reg[i] <= own_reg[i-1];
            end
            // setup: quotient of at least 2^DW means saturation
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            low_reg[0]  <= num[DW-1:0];
            dmag_reg[0] <= det_mag;
            neg_reg[0]  <= cneg_reg[DLY] ^ det_flags.neg;
            big_reg[0]  <= (RW'(num[NW-1:DW]) >= RW'(det_mag));
            zero_reg[0] <= det_flags.zero;
            for (int k = 1; k <= DW; k++) begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                low_reg[k]  <= low_reg[k-1];
                dmag_reg[k] <= dmag_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                big_reg[k]  <= big_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            // singular matrix passes the element through
            b_reg         <= zero_reg[DW] ? own_reg[OWN_D-1] : qval[DW-1:0];
            stat_reg.ovf  <= !zero_reg[DW] && sat;
            stat_reg.sing <= zero_reg[DW];
        end
    end

    assign b    = b_reg;
    assign stat = stat_reg;

endmodule

/* hdl/matrix3x3_inverse_core.sv */
// 3x3 matrix inverse by adjugate over determinant, signed fixed point
// (DATA_WIDTH bits, FRAC_BITS fraction bits). One matrix is taken per clock
// while s_ready is high; the input stalls when a finished result is blocked
// at the output. The per-element divider resolves one quotient bit per
// pipeline stage in each of nine parallel lanes, behind a six-stage
// determinant unit. A zero determinant returns the input matrix with
// m_singular set; saturated elements set m_overflow.
module matrix3x3_inverse_core #(
    parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_a00,
    input  logic [DATA_WIDTH-1:0] s_a01,
    input  logic [DATA_WIDTH-1:0] s_a02,
    input  logic [DATA_WIDTH-1:0] s_a10,
    input  logic [DATA_WIDTH-1:0] s_a11,
    input  logic [DATA_WIDTH-1:0] s_a12,
    input  logic [DATA_WIDTH-1:0] s_a20,
    input  logic [DATA_WIDTH-1:0] s_a21,
    input  logic [DATA_WIDTH-1:0] s_a22,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_b00,
    output logic [DATA_WIDTH-1:0] m_b01,
    output logic [DATA_WIDTH-1:0] m_b02,
    output logic [DATA_WIDTH-1:0] m_b10,
    output logic [DATA_WIDTH-1:0] m_b11,
    output logic [DATA_WIDTH-1:0] m_b12,
    output logic [DATA_WIDTH-1:0] m_b20,
    output logic [DATA_WIDTH-1:0] m_b21,
    output logic [DATA_WIDTH-1:0] m_b22,
    output logic                  m_singular,
    output logic                  m_overflow
);
    import m3i_pkg::*;

    localparam int DW       = DATA_WIDTH;
    localparam int PIPE_LAT = DET_LAT + DW + 2;

    logic [8:0][DW-1:0]  mat;
    logic [3*DW-1:0]     det_mag;
    det_flags_t          det_flags;
    logic [DW-1:0]       lane_b    [NUM_ELEM];
    lane_stat_t          lane_stat [NUM_ELEM];
    logic                vld_reg   [PIPE_LAT];
    logic                en;
    logic                out_valid_reg;
    logic [DW-1:0]       out_b_reg [NUM_ELEM];
    logic                sing_reg, ovf_reg, ovf_next;

    assign mat = {s_a22, s_a21, s_a20, s_a12, s_a11, s_a10, s_a02, s_a01, s_a00};

    // whole pipeline moves unless a finished beat is blocked at the output
    assign en      = m_ready || !out_valid_reg || !vld_reg[PIPE_LAT-1];
    assign s_ready = en;

    m3i_det #(
        .DATA_WIDTH(DW)
    ) u_det (
        .aclk      (aclk),
        .en        (en),
        .mat       (mat),
        .det_mag   (det_mag),
        .det_flags (det_flags)
    );

    // one lane per output element
    for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
        m3i_lane #(
            .DATA_WIDTH(DW),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .en        (en),
            .x         ($signed(mat[COF_IDX[i][0]])),
            .y         ($signed(mat[COF_IDX[i][1]])),
            .u         ($signed(mat[COF_IDX[i][2]])),
            .v         ($signed(mat[COF_IDX[i][3]])),
            .own       (mat[i]),
            .det_mag   (det_mag),
            .det_flags (det_flags),
            .b         (lane_b[i]),
            .stat      (lane_stat[i])
        );
    end

    // merge lane overflow flags
    always_comb begin
        ovf_next = 1'b0;
        for (int i = 0; i < NUM_ELEM; i++) begin
            ovf_next = ovf_next | lane_stat[i].ovf;
        end
    end

    // beat valid tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            out_valid_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if ((m_ready || !out_valid_reg) && vld_reg[PIPE_LAT-1]) begin
            for (int i = 0; i < NUM_ELEM; i++) begin
                out_b_reg[i] <= lane_b[i];
            end
            sing_reg <= lane_stat[0].sing;
            ovf_reg  <= ovf_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_b00      = out_b_reg[0];
    assign m_b01      = out_b_reg[1];
    assign m_b02      = out_b_reg[2];
    assign m_b10      = out_b_reg[3];
    assign m_b11      = out_b_reg[4];
    assign m_b12      = out_b_reg[5];
    assign m_b20      = out_b_reg[6];
    assign m_b21      = out_b_reg[7];
    assign m_b22      = out_b_reg[8];
    assign m_singular = sing_reg;
    assign m_overflow = ovf_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty output register");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_singular && m_overflow))
        else $error("singular and overflow both set");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && vld_reg[PIPE_LAT-1]) |-> !s_ready)
        else $error("input taken while pipeline is blocked");

    a_accept_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted beat not tracked");

endmodule

/* sim/matrix3x3_inverse_checker.sv */
module matrix3x3_inverse_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  logic [287:0]  s_mat,
    input  logic          m_valid,
    input  logic          m_ready,
    input  logic [287:0]  m_mat,
    input  logic          m_singular,
    input  logic          m_overflow,
    output int            err_count,
    output int            inv_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] b [9];
        logic        sing;
        logic        ovf;
    } inverse_t;

    inverse_t inv_q [$];

    // one rounded, saturated element of cof * 2^32 / det
    function automatic logic [31:0] quotient_elem(input logic signed [127:0] cof,
                                                  input logic signed [127:0] det,
                                                  inout logic ovf);
        logic        neg;
        logic [127:0] num, den, q, r, lim;
        neg = (cof < 0) != (det < 0);
        num = (cof < 0) ? -cof : cof;
        num = num << 32;
        den = (det < 0) ? -det : det;
        q = num / den;
        r = num % den;
        if ((r << 1) >= den) q = q + 1;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        if (q > lim) begin
            ovf = 1'b1;
            q = lim;
        end
        return neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    function automatic inverse_t invert_matrix(input logic [287:0] mat);
        inverse_t r;
        logic signed [127:0] e [9];
        logic signed [127:0] det;
        logic signed [127:0] cof [9];
        logic ovf;
        for (int i = 0; i < 9; i++) e[i] = {{96{mat[32*i+31]}}, mat[32*i +: 32]};
        det = e[0]*e[4]*e[8] + e[1]*e[5]*e[6] + e[2]*e[3]*e[7]
            - e[6]*e[4]*e[2] - e[3]*e[1]*e[8] - e[0]*e[7]*e[5];
        ovf = 1'b0;
        r.sing = (det == 0);
        // singular: matrix passes through
        if (r.sing) begin
            for (int i = 0; i < 9; i++) r.b[i] = mat[32*i +: 32];
            r.ovf = 1'b0;
            return r;
        end
        cof[0] = e[4]*e[8] - e[5]*e[7];
        cof[1] = e[2]*e[7] - e[1]*e[8];
        cof[2] = e[1]*e[5] - e[2]*e[4];
        cof[3] = e[5]*e[6] - e[3]*e[8];
        cof[4] = e[0]*e[8] - e[2]*e[6];
        cof[5] = e[2]*e[3] - e[0]*e[5];
        cof[6] = e[3]*e[7] - e[4]*e[6];
        cof[7] = e[1]*e[6] - e[0]*e[7];
        cof[8] = e[0]*e[4] - e[1]*e[3];
        for (int i = 0; i < 9; i++) r.b[i] = quotient_elem(cof[i], det, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    assign inv_pending = inv_q.size();

    initial err_count = 0;

    // predict on input beats, compare on result beats
    always @(posedge aclk) begin
        inverse_t exp_inv;
        int       errs;
        errs = 0;
        if (aresetn && s_valid && s_ready) inv_q.push_back(invert_matrix(s_mat));
        if (aresetn && m_valid && m_ready) begin
            if (inv_q.size() == 0) begin
                $display("%0t: result beat with no matrix outstanding", $realtime);
                errs++;
            end else begin
                exp_inv = inv_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_mat[32*i +: 32] !== exp_inv.b[i]) begin
                        $display("%0t: b%0d%0d expected %h actual %h", $realtime,
                                 i / 3, i % 3, exp_inv.b[i], m_mat[32*i +: 32]);
                        errs++;
                    end
                if (m_singular !== exp_inv.sing) begin
                    $display("%0t: singular expected %b actual %b", $realtime,
                             exp_inv.sing, m_singular);
                    errs++;
                end
                if (m_overflow !== exp_inv.ovf) begin
                    $display("%0t: overflow expected %b actual %b", $realtime,
                             exp_inv.ovf, m_overflow);
                    errs++;
                end
            end
        end
        if (errs > 0) err_count <= err_count + errs;
    end

endmodule

/* sim/matrix3x3_inverse_core_test.sv */
module matrix3x3_inverse_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE       = 32'h0001_0000;
    localparam int CYCLE_MAX = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_a [9];
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_b [9];
    logic        m_singular, m_overflow;
    logic [287:0] s_mat, m_mat;
    int          err_count, inv_pending;
    int          cycle_cnt = 0;
    logic        stim_done = 1'b0;

    initial for (int i = 0; i < 9; i++) s_a[i] = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    for (genvar g = 0; g < 9; g++) begin : g_pack
        assign s_mat[32*g +: 32] = s_a[g];
        assign m_mat[32*g +: 32] = m_b[g];
    end

    matrix3x3_inverse_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a00(s_a[0]), .s_a01(s_a[1]), .s_a02(s_a[2]),
        .s_a10(s_a[3]), .s_a11(s_a[4]), .s_a12(s_a[5]),
        .s_a20(s_a[6]), .s_a21(s_a[7]), .s_a22(s_a[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_b00(m_b[0]), .m_b01(m_b[1]), .m_b02(m_b[2]),
        .m_b10(m_b[3]), .m_b11(m_b[4]), .m_b12(m_b[5]),
        .m_b20(m_b[6]), .m_b21(m_b[7]), .m_b22(m_b[8]),
        .m_singular(m_singular), .m_overflow(m_overflow)
    );

    matrix3x3_inverse_checker u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mat(s_mat),
        .m_valid(m_valid), .m_ready(m_ready), .m_mat(m_mat),
        .m_singular(m_singular), .m_overflow(m_overflow),
        .err_count(err_count), .inv_pending(inv_pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_MAX) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall before each beat, sometimes none for a while
    initial begin
        int stall;
        int calm;
        calm = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
                if ($urandom_range(0, 31) == 0) calm = $urandom_range(10, 40);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_valid);
            @(posedge aclk);
        end
    end

    int calm_in = 0;

    task automatic send_matrix(input logic [31:0] m [9]);
        int gap;
        if (calm_in > 0) begin
            calm_in--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 31) == 0) calm_in = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        for (int i = 0; i < 9; i++) s_a[i] <= m[i];
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic send_diag(input logic [31:0] d0, d1, d2);
        logic [31:0] m [9];
        m = '{d0, 0, 0, 0, d1, 0, 0, 0, d2};
        send_matrix(m);
    endtask

    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 8 * ONE) - 4 * ONE;
            default: return $urandom_range(0, 1024) - 512;
        endcase
    endfunction

    initial begin
        logic [31:0] m [9];
        int kind;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_diag(ONE, ONE, ONE);
        send_diag(2 * ONE, -4 * ONE, ONE / 2);
        send_diag(1, 1, 1);
        send_diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_diag(32'h8000_0000, 1, 32'h7fff_ffff);
        send_diag(3 * ONE, 3 * ONE, 3 * ONE);
        send_diag(-ONE, -ONE, -ONE);
        m = '{default: 0};
        send_matrix(m);
        m = '{default: 32'hffff_ffff};
        send_matrix(m);
        m = '{default: 32'h7fff_ffff};
        send_matrix(m);
        m = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 7 * ONE, 8 * ONE, 9 * ONE};
        send_matrix(m);
        m = '{2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE};
        send_matrix(m);
        m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};
        send_matrix(m);
        m = '{32'h8000_0000, 32'h7fff_ffff, 1, 32'hffff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 0, 1, 32'h8000_0000};
        send_matrix(m);
        m = '{ONE, 1, 0, 0, ONE, 1, 1, 0, ONE};
        send_matrix(m);

        // random matrices: mostly regular with varied magnitude, some singular
        repeat (450) begin
            kind = $urandom_range(0, 2);
            for (int i = 0; i < 9; i++) m[i] = rand_elem(kind);
            case ($urandom_range(0, 7))
                0: for (int c = 0; c < 3; c++) m[6 + c] = m[c];
                1: for (int r = 0; r < 3; r++) m[3 * r + 2] = m[3 * r + 1];
                2: for (int c = 0; c < 3; c++) m[3 + c] = 0;
                3: begin
                    m = '{default: 0};
                    m[0] = rand_elem(2); m[4] = rand_elem(2); m[8] = rand_elem(2);
                end
                default: ;
            endcase
            send_matrix(m);
        end
        s_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // verdict
    initial begin
        @(posedge stim_done);
        while (inv_pending > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (err_count == 0 && inv_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/m3i_pkg.sv
hdl/m3i_det.sv
hdl/m3i_lane.sv
hdl/matrix3x3_inverse_core.sv
sim/matrix3x3_inverse_checker.sv
sim/matrix3x3_inverse_core_test.sv
